// ----- hdl/sbd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and codes for the DEFLATE stored block deframer.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_LITERAL     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END         = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNSUPPORTED = 2'd3;

    localparam logic [1:0] BTYPE_STORED   = 2'd0;
    localparam logic [1:0] BTYPE_RESERVED = 2'd3;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_LEN_LO  = 7'b0000010,
        PH_LEN_HI  = 7'b0000100,
        PH_NLEN_LO = 7'b0001000,
        PH_NLEN_HI = 7'b0010000,
        PH_DATA    = 7'b0100000,
        PH_CLOSED  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic              stream_end;
    } t_result;

endpackage

// ----- hdl/sbd_in_stage.sv -----
// ----------------------------------------------------------------------------
// sbd_in_stage
// Input register for stream bytes, one item deep, refilled in the same cycle.
// ----------------------------------------------------------------------------
module sbd_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [sbd_pkg::BYTE_W-1:0] i_byte,
    output logic                      o_valid,
    input  logic                      i_take,
    output logic [sbd_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic                       n_valid;
    logic [sbd_pkg::BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ----- hdl/sbd_step.sv -----
// ----------------------------------------------------------------------------
// sbd_step
// Block parser state and the per-byte step that decides each result.
// ----------------------------------------------------------------------------
module sbd_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [sbd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_emit,
    output sbd_pkg::t_result           o_result
);

    sbd_pkg::t_phase            r_phase;
    sbd_pkg::t_phase            n_phase;
    logic                       r_final;
    logic                       n_final;
    logic [sbd_pkg::WORD_W-1:0] r_remain;
    logic [sbd_pkg::WORD_W-1:0] n_remain;
    logic [sbd_pkg::BYTE_W-1:0] r_nlen_lo;
    logic [sbd_pkg::BYTE_W-1:0] n_nlen_lo;
    logic [sbd_pkg::WORD_W-1:0] nlen_word;
    logic [1:0]                 btype;

    assign nlen_word = {i_byte, r_nlen_lo};
    assign btype     = i_byte[2:1];

    always_comb begin
        n_phase   = r_phase;
        n_final   = r_final;
        n_remain  = r_remain;
        n_nlen_lo = r_nlen_lo;
        o_emit    = 1'b0;
        o_result  = '0;
        case (r_phase)
            sbd_pkg::PH_HEADER: begin
                n_final = i_byte[0];
                if (btype == sbd_pkg::BTYPE_STORED) begin
                    n_phase = sbd_pkg::PH_LEN_LO;
                end else begin
                    n_phase             = sbd_pkg::PH_CLOSED;
                    o_emit              = 1'b1;
                    o_result.stream_end = 1'b1;
                    o_result.kind       = (btype == sbd_pkg::BTYPE_RESERVED) ?
                                          sbd_pkg::KIND_INVALID :
                                          sbd_pkg::KIND_UNSUPPORTED;
                end
            end
            sbd_pkg::PH_LEN_LO: begin
                n_remain = {{(sbd_pkg::WORD_W-sbd_pkg::BYTE_W){1'b0}}, i_byte};
                n_phase  = sbd_pkg::PH_LEN_HI;
            end
            sbd_pkg::PH_LEN_HI: begin
                n_remain = {i_byte, r_remain[sbd_pkg::BYTE_W-1:0]};
                n_phase  = sbd_pkg::PH_NLEN_LO;
            end
            sbd_pkg::PH_NLEN_LO: begin
                n_nlen_lo = i_byte;
                n_phase   = sbd_pkg::PH_NLEN_HI;
            end
            sbd_pkg::PH_NLEN_HI: begin
                if (r_remain != ~nlen_word) begin
                    n_phase             = sbd_pkg::PH_CLOSED;
                    o_emit              = 1'b1;
                    o_result.kind       = sbd_pkg::KIND_INVALID;
                    o_result.stream_end = 1'b1;
                end else if (r_remain == '0) begin
                    if (r_final) begin
                        n_phase             = sbd_pkg::PH_CLOSED;
                        o_emit              = 1'b1;
                        o_result.kind       = sbd_pkg::KIND_END;
                        o_result.stream_end = 1'b1;
                    end else begin
                        n_phase = sbd_pkg::PH_HEADER;
                    end
                end else begin
                    n_phase = sbd_pkg::PH_DATA;
                end
            end
            sbd_pkg::PH_DATA: begin
                n_remain          = r_remain - 1'b1;
                o_emit            = 1'b1;
                o_result.kind     = sbd_pkg::KIND_LITERAL;
                o_result.out_byte = i_byte;
                if (n_remain == '0) begin
                    if (r_final) begin
                        n_phase             = sbd_pkg::PH_CLOSED;
                        o_result.stream_end = 1'b1;
                    end else begin
                        n_phase = sbd_pkg::PH_HEADER;
                    end
                end
            end
            sbd_pkg::PH_CLOSED: begin
                n_phase = sbd_pkg::PH_CLOSED;
            end
            default: begin
                n_phase = sbd_pkg::PH_CLOSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sbd_pkg::PH_HEADER;
            r_final   <= 1'b0;
            r_remain  <= '0;
            r_nlen_lo <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_final   <= n_final;
            r_remain  <= n_remain;
            r_nlen_lo <= n_nlen_lo;
        end
    end

endmodule

// ----- hdl/sbd_out_stage.sv -----
// ----------------------------------------------------------------------------
// sbd_out_stage
// Result register; frees its slot in the cycle the receiver takes it.
// ----------------------------------------------------------------------------
module sbd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sbd_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output sbd_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    sbd_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- hdl/deflate_stored_block_deframer.sv -----
// ----------------------------------------------------------------------------
// deflate_stored_block_deframer
// Parses stored DEFLATE blocks from a byte stream and passes their data on.
//
// Input channel: i_in_valid / o_in_ready carry one stream byte per item on
// i_data_byte. Output channel: o_out_valid / i_out_ready carry one result
// item on o_kind, o_out_byte and o_stream_end. Header, LEN and NLEN bytes
// produce a result item only when they close the stream; bytes after the
// stream has closed produce none. A byte passes through the input register,
// then the result register. Throughput: one byte per cycle while the receiver
// takes results, set by the single step of the parser state.
// When the receiver stalls, the result register holds, the parser holds,
// and the input register takes at most one more byte before o_in_ready drops.
// Reset clears both registers to empty and the parser to await a header.
// ----------------------------------------------------------------------------
module deflate_stored_block_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [sbd_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [sbd_pkg::KIND_W-1:0]  o_kind,
    output logic [sbd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_stream_end
);

    logic                       stage_valid;
    logic [sbd_pkg::BYTE_W-1:0] stage_byte;
    logic                       out_free;
    logic                       take;
    logic                       emit;
    sbd_pkg::t_result           step_result;
    sbd_pkg::t_result           out_result;

    assign take = stage_valid && out_free;

    sbd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_data_byte),
        .o_valid (stage_valid),
        .i_take  (take),
        .o_byte  (stage_byte)
    );

    sbd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (stage_byte),
        .o_emit   (emit),
        .o_result (step_result)
    );

    sbd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_kind       = out_result.kind;
    assign o_out_byte   = out_result.out_byte;
    assign o_stream_end = out_result.stream_end;

endmodule

// ----- verif/deflate_stored_block_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// deflate_stored_block_deframer_tb
// Feeds one long DEFLATE stream of stored blocks through the deframer and
// checks every result item against a cycle-free model of the block parser.
// The stream opens with directed blocks and continues with random
// non-final blocks. It closes with one closing case picked at random (final
// data, final empty block, LEN/NLEN mismatch, reserved or Huffman type),
// followed by bytes that must be ignored. Sender gaps and receiver stalls
// vary by phase.
// ----------------------------------------------------------------------------
module deflate_stored_block_deframer_tb;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned STREAM_ITEMS = 1900;

    localparam logic [1:0] BTYPE_FIXED   = 2'd1;
    localparam logic [1:0] BTYPE_DYNAMIC = 2'd2;

    typedef enum int {
        CLOSE_FINAL_DATA,
        CLOSE_FINAL_EMPTY,
        CLOSE_LEN_MISMATCH,
        CLOSE_RESERVED,
        CLOSE_FIXED_HUFF,
        CLOSE_DYNAMIC_HUFF
    } t_close;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic [sbd_pkg::BYTE_W-1:0] i_data_byte = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [sbd_pkg::KIND_W-1:0] o_kind;
    logic [sbd_pkg::BYTE_W-1:0] o_out_byte;
    logic                       o_stream_end;

    logic [sbd_pkg::BYTE_W-1:0] stream_bytes[$];
    sbd_pkg::t_result           expected_results[$];
    int                         bytes_taken    = 0;
    int                         mismatch_count = 0;
    int                         quiet_cycles   = 0;
    int                         src_idle_pct   = 0;
    int                         sink_stall_pct = 0;

    sbd_pkg::t_phase            pr_phase = sbd_pkg::PH_HEADER;
    logic                       pr_final = 1'b0;
    logic [sbd_pkg::WORD_W-1:0] pr_len   = '0;
    logic [sbd_pkg::WORD_W-1:0] pr_nlen  = '0;

    deflate_stored_block_deframer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_stream_end (o_stream_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit deframe_byte(input logic [sbd_pkg::BYTE_W-1:0] b,
                                        output sbd_pkg::t_result r);
        logic [1:0] btype;
        r = '0;
        case (pr_phase)
            sbd_pkg::PH_HEADER: begin
                pr_final = b[0];
                btype    = b[2:1];
                if (btype == sbd_pkg::BTYPE_STORED) begin
                    pr_phase = sbd_pkg::PH_LEN_LO;
                    return 1'b0;
                end
                pr_phase     = sbd_pkg::PH_CLOSED;
                r.kind       = (btype == sbd_pkg::BTYPE_RESERVED) ?
                               sbd_pkg::KIND_INVALID : sbd_pkg::KIND_UNSUPPORTED;
                r.stream_end = 1'b1;
                return 1'b1;
            end
            sbd_pkg::PH_LEN_LO: begin
                pr_len   = {8'h00, b};
                pr_phase = sbd_pkg::PH_LEN_HI;
                return 1'b0;
            end
            sbd_pkg::PH_LEN_HI: begin
                pr_len[15:8] = b;
                pr_phase     = sbd_pkg::PH_NLEN_LO;
                return 1'b0;
            end
            sbd_pkg::PH_NLEN_LO: begin
                pr_nlen  = {8'h00, b};
                pr_phase = sbd_pkg::PH_NLEN_HI;
                return 1'b0;
            end
            sbd_pkg::PH_NLEN_HI: begin
                pr_nlen[15:8] = b;
                if (pr_len != ~pr_nlen) begin
                    pr_phase     = sbd_pkg::PH_CLOSED;
                    r.kind       = sbd_pkg::KIND_INVALID;
                    r.stream_end = 1'b1;
                    return 1'b1;
                end
                if (pr_len == '0) begin
                    if (pr_final) begin
                        pr_phase     = sbd_pkg::PH_CLOSED;
                        r.kind       = sbd_pkg::KIND_END;
                        r.stream_end = 1'b1;
                        return 1'b1;
                    end
                    pr_phase = sbd_pkg::PH_HEADER;
                    return 1'b0;
                end
                pr_phase = sbd_pkg::PH_DATA;
                return 1'b0;
            end
            sbd_pkg::PH_DATA: begin
                pr_len     = pr_len - 1'b1;
                r.kind     = sbd_pkg::KIND_LITERAL;
                r.out_byte = b;
                if (pr_len == '0) begin
                    if (pr_final) begin
                        pr_phase     = sbd_pkg::PH_CLOSED;
                        r.stream_end = 1'b1;
                    end else begin
                        pr_phase = sbd_pkg::PH_HEADER;
                    end
                end
                return 1'b1;
            end
            default: begin
                pr_phase = sbd_pkg::PH_CLOSED;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 50)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic push_header(input logic fin, input logic [1:0] btype,
                               input logic [4:0] upper);
        stream_bytes.push_back({upper, btype, fin});
    endtask

    task automatic push_word(input logic [sbd_pkg::WORD_W-1:0] w);
        stream_bytes.push_back(w[7:0]);
        stream_bytes.push_back(w[15:8]);
    endtask

    task automatic push_stored(input logic fin, input int len);
        logic [sbd_pkg::WORD_W-1:0] w;
        w = 16'(len);
        push_header(fin, sbd_pkg::BTYPE_STORED, 5'($urandom_range(31)));
        push_word(w);
        push_word(~w);
        repeat (len) stream_bytes.push_back(8'($urandom_range(255)));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (stream_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                i_data_byte <= stream_bytes.pop_front();
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        sbd_pkg::t_result want;
        sbd_pkg::t_result got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
            if (i_in_valid && o_in_ready) begin
                bytes_taken <= bytes_taken + 1;
                if (deframe_byte(i_data_byte, want))
                    expected_results.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got.kind       = o_kind;
                got.out_byte   = o_out_byte;
                got.stream_end = o_stream_end;
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with none pending, kind",
                                    int'(got.kind), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", int'(got.kind), int'(want.kind));
                    if (got.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(got.out_byte),
                                        int'(want.out_byte));
                    if (got.stream_end !== want.stream_end)
                        report_mismatch("stream_end", int'(got.stream_end),
                                        int'(want.stream_end));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout with %0d results pending", expected_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int                         total;
        int                         len;
        t_close                     how;
        logic [sbd_pkg::WORD_W-1:0] w;
        logic [sbd_pkg::WORD_W-1:0] mask;

        // empty block, then dropped header bits all set, then a single byte
        push_header(1'b0, sbd_pkg::BTYPE_STORED, 5'h00);
        push_word(16'h0000);
        push_word(16'hFFFF);
        push_header(1'b0, sbd_pkg::BTYPE_STORED, 5'h1F);
        push_word(16'd2);
        push_word(16'hFFFD);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        push_header(1'b0, sbd_pkg::BTYPE_STORED, 5'h15);
        push_word(16'd1);
        push_word(16'hFFFE);
        stream_bytes.push_back(8'hA5);

        push_stored(1'b0, 256 + $urandom_range(40));
        while (stream_bytes.size() < STREAM_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24);
            push_stored(1'b0, len);
        end

        how = t_close'($urandom_range(5));
        case (how)
            CLOSE_FINAL_DATA:  push_stored(1'b1, $urandom_range(20, 1));
            CLOSE_FINAL_EMPTY: push_stored(1'b1, 0);
            CLOSE_LEN_MISMATCH: begin
                w    = 16'($urandom_range(16'hFFFF));
                mask = $urandom_range(1) ? (16'h0001 << $urandom_range(15))
                                         : 16'($urandom_range(16'hFFFF, 1));
                push_header(1'($urandom_range(1)), sbd_pkg::BTYPE_STORED,
                            5'($urandom_range(31)));
                push_word(w);
                push_word(~w ^ mask);
            end
            CLOSE_RESERVED:
                push_header(1'($urandom_range(1)), sbd_pkg::BTYPE_RESERVED,
                            5'($urandom_range(31)));
            CLOSE_FIXED_HUFF:
                push_header(1'($urandom_range(1)), BTYPE_FIXED, 5'($urandom_range(31)));
            default:
                push_header(1'($urandom_range(1)), BTYPE_DYNAMIC, 5'($urandom_range(31)));
        endcase
        // bytes after close must be ignored
        repeat (16) stream_bytes.push_back(8'($urandom_range(255)));
        total = stream_bytes.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct <= 66; sink_stall_pct <= 0;  end
                2: begin src_idle_pct <= 0;  sink_stall_pct <= 66; end
                default: begin src_idle_pct <= 30; sink_stall_pct <= 30; end
            endcase
            while (bytes_taken < total * (p + 1) / 4) @(posedge i_clk);
        end

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sbd_pkg.sv
hdl/sbd_in_stage.sv
hdl/sbd_step.sv
hdl/sbd_out_stage.sv
hdl/deflate_stored_block_deframer.sv
verif/deflate_stored_block_deframer_tb.sv
